[hdl/pwrm_pkg.sv]
// Package for the packet window rate meter.
// Holds field widths, defaults and the control record shared between modules.
// No dependencies.
package pwrm_pkg;

  localparam int unsigned WINDOW_DEFAULT = 128;
  localparam int unsigned BYTES_W        = 16;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned RATE_W         = 39;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned DIV_STEP_BITS  = 2;

  typedef struct packed {
    logic valid;
    logic full;
    logic zero_interval;
  } job_ctrl_t;

endpackage

[hdl/pwrm_in_if.sv]
// Input channel of the packet window rate meter: one packet per transaction.
// Depends on pwrm_pkg.
interface pwrm_in_if;
  import pwrm_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTES_W-1:0] pkt_bytes;
  logic [TIME_W-1:0]  arrival_time;

  modport source (output valid, output pkt_bytes, output arrival_time, input ready);
  modport sink (input valid, input pkt_bytes, input arrival_time, output ready);
endinterface

[hdl/pwrm_out_if.sv]
// Output channel of the packet window rate meter: one rate per transaction.
// Depends on pwrm_pkg.
interface pwrm_out_if;
  import pwrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate;
  logic              rate_valid;

  modport source (output valid, output rate, output rate_valid, input ready);
  modport sink (input valid, input rate, input rate_valid, output ready);
endinterface

[hdl/pwrm_window.sv]
// Window store: size and time rings in synchronous memories, running byte sum,
// write slot and fill count. Read in the start cycle, modify and write back next.
// Depends on pwrm_pkg.
module pwrm_window #(
  parameter int unsigned WINDOW = pwrm_pkg::WINDOW_DEFAULT,
  parameter int unsigned SUM_W  = 23
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [pwrm_pkg::BYTES_W-1:0]     pkt_bytes,
  input  logic [pwrm_pkg::TIME_W-1:0]      arrival_time,
  output pwrm_pkg::job_ctrl_t              job_ctrl,
  output logic [SUM_W-1:0]                 job_sum,
  output logic [pwrm_pkg::TIME_W-1:0]      job_interval
);
  import pwrm_pkg::*;

  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned FILL_W = $clog2(WINDOW + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);

  logic [BYTES_W-1:0] size_mem [WINDOW];
  logic [TIME_W-1:0]  time_mem [WINDOW];

  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  slot_next;
  logic [FILL_W-1:0]  fill_count;
  logic [SUM_W-1:0]   byte_sum;
  logic [SUM_W-1:0]   sum_next;
  logic [TIME_W-1:0]  interval_next;
  logic               pend;
  logic               full_before;
  logic               full_after;
  logic [BYTES_W-1:0] bytes_q;
  logic [TIME_W-1:0]  now_q;
  logic [BYTES_W-1:0] size_rd;
  logic [TIME_W-1:0]  time_rd;

  assign slot_next     = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign full_before   = (fill_count == FILL_FULL);
  assign full_after    = full_before || (fill_count == FILL_LAST);
  assign sum_next      = byte_sum - (full_before ? SUM_W'(size_rd) : '0) + SUM_W'(bytes_q);
  assign interval_next = now_q - time_rd;

  // The oldest entry sits in the write slot and is overwritten; the oldest that stays
  // sits one slot past it. Only one packet is in flight, so a read never meets a pending write.
  always_ff @(posedge clk) begin
    if (start) begin
      size_rd <= size_mem[write_slot];
      time_rd <= time_mem[slot_next];
      bytes_q <= pkt_bytes;
      now_q   <= arrival_time;
    end
    if (pend) begin
      size_mem[write_slot] <= bytes_q;
      time_mem[write_slot] <= now_q;
      job_sum              <= sum_next;
      job_interval         <= interval_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      write_slot <= '0;
      fill_count <= '0;
      byte_sum   <= '0;
      job_ctrl   <= '0;
    end else begin
      pend           <= start;
      job_ctrl.valid <= pend;
      if (pend) begin
        byte_sum               <= sum_next;
        write_slot             <= slot_next;
        job_ctrl.full          <= full_after;
        job_ctrl.zero_interval <= (interval_next == '0);
        if (!full_before) begin
          fill_count <= fill_count + 1'b1;
        end
      end
    end
  end
endmodule

[hdl/pwrm_div.sv]
// Iterative restoring divider, DIV_STEP_BITS quotient bits per cycle while busy.
// Divides the scaled byte sum by the 32-bit interval. Depends on pwrm_pkg.
module pwrm_div #(
  parameter int unsigned DVD_W = 39
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [DVD_W-1:0]            dividend,
  input  logic [pwrm_pkg::TIME_W-1:0] divisor,
  output logic                        done,
  output logic [DVD_W-1:0]            quotient
);
  import pwrm_pkg::*;

  localparam int unsigned ITER  = (DVD_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned PAD_W = ITER * DIV_STEP_BITS;
  localparam int unsigned CNT_W = $clog2(ITER + 1);

  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] rem_next;
  logic [PAD_W-1:0]  quo;
  logic [PAD_W-1:0]  quo_next;
  logic [TIME_W-1:0] dsr;

  always_comb begin
    logic [TIME_W-1:0] r;
    logic [PAD_W-1:0]  q;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              ge;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      trial = {r, q[PAD_W-1]};
      diff  = trial - {1'b0, dsr};
      ge    = (trial >= {1'b0, dsr});
      r     = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      q     = {q[PAD_W-2:0], ge};
    end
    rem_next = r;
    quo_next = q;
  end

  assign quotient = quo[DVD_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= PAD_W'(dividend);
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ITER);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[hdl/packet_window_rate_meter.sv]
// Top level of the packet window rate meter: sequencing, saturation, output register.
// Depends on pwrm_pkg, pwrm_in_if, pwrm_out_if, pwrm_window and pwrm_div.
//
//   channel    direction  payload                      per transaction
//   pkt_in     sink       pkt_bytes, arrival_time      one received packet
//   rate_out   source     rate, rate_valid             one window rate
//
// A packet whose window is full and whose interval is nonzero goes through the divider,
// which retires two quotient bits a cycle; other packets skip it with rate_valid low.
// One packet is in flight at a time.
// Synchronous reset clears the sum, the slot and the fill count; the rings need none.
// A stalled rate_out holds its result while the next packet is already taken in.
module packet_window_rate_meter #(
  parameter int unsigned WINDOW = pwrm_pkg::WINDOW_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  pwrm_in_if.sink   pkt_in,
  pwrm_out_if.source rate_out
);
  import pwrm_pkg::*;

  localparam int unsigned SUM_W =
      $clog2(longint'(WINDOW) * ((longint'(1) << BYTES_W) - 1) + 1);
  localparam int unsigned DVD_W = SUM_W + FRAC_W;

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_DIVIDE, S_RESULT} state_t;

  state_t            state;
  job_ctrl_t         job_ctrl;
  logic [SUM_W-1:0]  job_sum;
  logic [TIME_W-1:0] job_interval;
  logic              accept;
  logic              div_go;
  logic              div_done;
  logic [DVD_W-1:0]  quotient;
  logic [RATE_W-1:0] rate_sat;
  logic [RATE_W-1:0] res_rate;
  logic              res_valid;
  logic              out_valid;
  logic [RATE_W-1:0] out_rate;
  logic              out_rate_valid;

  assign pkt_in.ready        = (state == S_IDLE);
  assign accept              = pkt_in.valid && (state == S_IDLE);
  assign div_go              = job_ctrl.valid && job_ctrl.full && !job_ctrl.zero_interval;
  assign rate_out.valid      = out_valid;
  assign rate_out.rate       = out_rate;
  assign rate_out.rate_valid = out_rate_valid;

  generate
    if (DVD_W > RATE_W) begin : g_sat
      assign rate_sat = (|quotient[DVD_W-1:RATE_W]) ? '1 : quotient[RATE_W-1:0];
    end else begin : g_nosat
      assign rate_sat = RATE_W'(quotient);
    end
  endgenerate

  pwrm_window #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .start        (accept),
    .pkt_bytes    (pkt_in.pkt_bytes),
    .arrival_time (pkt_in.arrival_time),
    .job_ctrl     (job_ctrl),
    .job_sum      (job_sum),
    .job_interval (job_interval)
  );

  pwrm_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend ({job_sum, FRAC_W'(0)}),
    .divisor  (job_interval),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rate_out.ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (job_ctrl.valid) begin
            if (div_go) begin
              state <= S_DIVIDE;
            end else begin
              res_rate  <= '0;
              res_valid <= 1'b0;
              state     <= S_RESULT;
            end
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            res_rate  <= rate_sat;
            res_valid <= 1'b1;
            state     <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || rate_out.ready) begin
            out_valid      <= 1'b1;
            out_rate       <= res_rate;
            out_rate_valid <= res_valid;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
